/* hdl/bba_pkg.sv */
package bba_pkg;

	// Region geometry.
	localparam int TOTAL_LOG2 = 20;
	localparam int MIN_LOG2   = 12;
	localparam int LEVELS     = TOTAL_LOG2 - MIN_LOG2;

	// Tree geometry: one node per block of every order, root at index 0.
	localparam int NODE_W     = LEVELS + 1;
	localparam int NODE_COUNT = (1 << NODE_W) - 1;

	// Field widths.
	localparam int ADDR_W = TOTAL_LOG2;
	localparam int SIZE_W = TOTAL_LOG2 + 1;
	localparam int ORD_W  = 4;
	localparam int STAT_W = 2;
	localparam int AIDX_W = $clog2(ADDR_W);
	localparam int UIDX_W = $clog2(LEVELS);

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 2'd0,
		ST_NO_SPACE = 2'd1,
		ST_INTERNAL = 2'd2,
		ST_NO_BLOCK = 2'd3
	} status_t;

	// One tree node: split flag and largest free order below it plus one.
	typedef struct packed {
		logic             split;
		logic [ORD_W-1:0] free;
	} node_t;

	// Access to the node store for one cycle.
	typedef struct packed {
		logic              rd_en;
		logic [NODE_W-1:0] rd_addr;
		logic              wr_en;
		logic [NODE_W-1:0] wr_addr;
		node_t             wr_data;
	} ram_req_t;

	// Result word handed from the sequencer to the output register.
	typedef struct packed {
		status_t           status;
		logic [ADDR_W-1:0] addr;
		logic [ORD_W-1:0]  order;
	} result_t;

endpackage

/* hdl/buddy_block_allocator.sv */
// A request runs from the accepting edge through decode; a request rejected at decode goes
// straight to the result word in the output register, others first descend the tree level
// by level, merge (free only) and refresh the free orders on each level on the way up.
// Requests are handled one at a time; the next word can be taken in the cycle after the
// sequencer hands its result to the output register.
// Reset: arst_n clears the sequencer and output valid and makes the root one free block.
module buddy_block_allocator (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       func,
	input  logic [bba_pkg::SIZE_W-1:0] request_size,
	input  logic [bba_pkg::ADDR_W-1:0] block_address,
	input  logic [bba_pkg::ORD_W-1:0]  block_order,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [bba_pkg::STAT_W-1:0] status,
	output logic [bba_pkg::ADDR_W-1:0] granted_address,
	output logic [bba_pkg::ORD_W-1:0]  granted_order
);
	import bba_pkg::*;

	// The tree is held in a node store: one entry per block of every order,
	// root at index 0, children of node n at 2n+1 and 2n+2. Each entry keeps
	// a split flag and the largest free order below it plus one. Only nodes
	// whose ancestors are all split are ever read, and every such node is
	// written when its parent splits, so the store needs no clearing after
	// reset; only the root register is reset.

	ram_req_t ram_req;
	node_t    rd_data;
	logic     busy;
	logic     res_valid;
	logic     res_take;
	result_t  res;

	logic                out_valid_q;
	logic [STAT_W-1:0]   status_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [ORD_W-1:0]    order_q;

	// The sequencer walks the tree: a descent to
	// the target block, then merges (free only), then a refresh of the free
	// orders along the path back to the root.
	bba_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.func          (func),
		.request_size  (request_size),
		.block_address (block_address),
		.block_order   (block_order),
		.busy          (busy),
		.res_valid     (res_valid),
		.res_take      (res_take),
		.res           (res),
		.ram_req       (ram_req),
		.rd_data       (rd_data)
	);

	bba_node_ram u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (ram_req),
		.rd_data (rd_data)
	);

	// A new word is taken whenever the sequencer is idle, even while an
	// earlier result still waits in the output register.
	assign in_stall = busy;

	// The output register frees up in the same cycle its word is taken.
	assign res_take = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_take) begin
			status_q <= res.status;
			addr_q   <= res.addr;
			order_q  <= res.order;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign granted_address = addr_q;
	assign granted_order   = order_q;

endmodule

/* hdl/bba_node_ram.sv */
module bba_node_ram (
	input  logic              clk,
	input  logic              arst_n,
	input  bba_pkg::ram_req_t req,
	output bba_pkg::node_t    rd_data
);
	import bba_pkg::*;

	// Nodes below the root live in the array; the root is a register so that
	// it comes out of reset as one free block covering the whole region.
	node_t node_mem_q [NODE_COUNT];
	node_t root_q;
	node_t rd_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q.split <= 1'b0;
			root_q.free  <= ORD_W'(LEVELS + 1);
		end else if (req.wr_en && req.wr_addr == '0) begin
			root_q <= req.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr_en && req.wr_addr != '0) begin
			node_mem_q[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= (req.rd_addr == '0) ? root_q : node_mem_q[req.rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* hdl/bba_seq.sv */
module bba_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          func,
	input  logic [bba_pkg::SIZE_W-1:0]    request_size,
	input  logic [bba_pkg::ADDR_W-1:0]    block_address,
	input  logic [bba_pkg::ORD_W-1:0]     block_order,
	output logic                          busy,
	output logic                          res_valid,
	input  logic                          res_take,
	output bba_pkg::result_t              res,
	output bba_pkg::ram_req_t             ram_req,
	input  bba_pkg::node_t                rd_data
);
	import bba_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DEC,
		S_A_CHK,
		S_A_LEFT,
		S_A_SPL,
		S_A_SPR,
		S_F_DESC,
		S_F_MRG,
		S_F_MW1,
		S_F_MW2,
		S_UP,
		S_DONE
	} state_t;

	function automatic logic [NODE_W-1:0] f_sibling(input logic [NODE_W-1:0] n);
		return n[0] ? n + NODE_W'(1) : n - NODE_W'(1);
	endfunction

	state_t              state_q;
	logic                func_q;
	logic [SIZE_W-1:0]   size_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [ORD_W-1:0]    k_q;
	logic [ORD_W-1:0]    ord_q;
	logic [ORD_W-1:0]    cur_q;
	logic [NODE_W-1:0]   node_q;
	logic [LEVELS-1:0]   unit_q;
	result_t             res_q;

	logic [ORD_W-1:0]    k_d;
	logic                too_big;
	logic                misaligned;
	logic [NODE_W-1:0]   left_n;
	logic [NODE_W-1:0]   right_n;
	logic [NODE_W-1:0]   par_n;
	logic [NODE_W-1:0]   sib_n;
	logic [NODE_W-1:0]   psib_n;
	logic                go_left;
	logic [NODE_W-1:0]   a_next;
	logic                dir;
	logic [NODE_W-1:0]   f_next;
	logic                mrg_ok;
	logic [ORD_W-1:0]    up_max;
	logic                root_short;

	// Smallest order whose block holds the request; zero bytes count as the
	// minimum block.
	always_comb begin
		k_d = ORD_W'(LEVELS);
		for (int j = LEVELS; j >= 0; j--) begin
			if (size_q <= (SIZE_W'(1) << (MIN_LOG2 + j))) k_d = ORD_W'(j);
		end
	end

	assign too_big = size_q > (SIZE_W'(1) << TOTAL_LOG2);

	always_comb begin
		misaligned = 1'b0;
		for (int j = 0; j < ADDR_W; j++) begin
			if (addr_q[j] && (j < MIN_LOG2 + int'(k_q))) misaligned = 1'b1;
		end
	end

	assign left_n  = {node_q[NODE_W-2:0], 1'b1};
	assign right_n = left_n + NODE_W'(1);
	assign par_n   = NODE_W'((node_q - NODE_W'(1)) >> 1);
	assign sib_n   = f_sibling(node_q);
	assign psib_n  = f_sibling(par_n);

	assign go_left    = rd_data.free > k_q;
	assign a_next     = go_left ? left_n : right_n;
	assign dir        = addr_q[AIDX_W'(MIN_LOG2) + AIDX_W'(ord_q) - AIDX_W'(1)];
	assign f_next     = dir ? right_n : left_n;
	assign mrg_ok     = !rd_data.split && (rd_data.free == ord_q + ORD_W'(1));
	assign up_max     = (cur_q >= rd_data.free) ? cur_q : rd_data.free;
	assign root_short = (node_q == '0) && (rd_data.free <= k_q);

	// Node store accesses. A read returns its data in the next cycle.
	always_comb begin
		ram_req = '0;
		case (state_q)
			S_DEC: begin
				ram_req.rd_en   = 1'b1;
				ram_req.rd_addr = '0;
			end
			S_A_CHK: begin
				if (root_short) begin
					ram_req.rd_en = 1'b0;
				end else if (!rd_data.split) begin
					ram_req.wr_en   = 1'b1;
					ram_req.wr_addr = node_q;
					if (ord_q == k_q) begin
						ram_req.wr_data = '0;
						ram_req.rd_en   = node_q != '0;
						ram_req.rd_addr = sib_n;
					end else begin
						ram_req.wr_data.split = 1'b1;
						ram_req.wr_data.free  = rd_data.free;
					end
				end else begin
					ram_req.rd_en   = 1'b1;
					ram_req.rd_addr = left_n;
				end
			end
			S_A_LEFT: begin
				ram_req.rd_en   = 1'b1;
				ram_req.rd_addr = a_next;
			end
			S_A_SPL: begin
				ram_req.wr_en        = 1'b1;
				ram_req.wr_addr      = left_n;
				ram_req.wr_data.free = ord_q;
			end
			S_A_SPR: begin
				ram_req.wr_en        = 1'b1;
				ram_req.wr_addr      = right_n;
				ram_req.wr_data.free = ord_q;
				ram_req.rd_en        = 1'b1;
				ram_req.rd_addr      = left_n;
			end
			S_F_DESC: begin
				if (ord_q == k_q) begin
					if (!rd_data.split && rd_data.free == '0) begin
						ram_req.wr_en        = 1'b1;
						ram_req.wr_addr      = node_q;
						ram_req.wr_data.free = k_q + ORD_W'(1);
						ram_req.rd_en        = node_q != '0;
						ram_req.rd_addr      = sib_n;
					end
				end else if (rd_data.split) begin
					ram_req.rd_en   = 1'b1;
					ram_req.rd_addr = f_next;
				end
			end
			S_F_MRG: begin
				if (mrg_ok) begin
					ram_req.wr_en        = 1'b1;
					ram_req.wr_addr      = par_n;
					ram_req.wr_data.free = ord_q + ORD_W'(2);
				end else begin
					ram_req.rd_en   = 1'b1;
					ram_req.rd_addr = sib_n;
				end
			end
			S_F_MW1: begin
				ram_req.wr_en   = 1'b1;
				ram_req.wr_addr = node_q;
			end
			S_F_MW2: begin
				ram_req.wr_en   = 1'b1;
				ram_req.wr_addr = sib_n;
				ram_req.rd_en   = par_n != '0;
				ram_req.rd_addr = psib_n;
			end
			S_UP: begin
				ram_req.wr_en         = 1'b1;
				ram_req.wr_addr       = par_n;
				ram_req.wr_data.split = 1'b1;
				ram_req.wr_data.free  = up_max;
				ram_req.rd_en         = par_n != '0;
				ram_req.rd_addr       = psib_n;
			end
			default: begin
				ram_req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			node_q  <= '0;
			ord_q   <= ORD_W'(LEVELS);
			func_q  <= 1'b0;
			size_q  <= '0;
			addr_q  <= '0;
			k_q     <= '0;
			cur_q   <= '0;
			unit_q  <= '0;
			res_q   <= '{ST_OK, '0, '0};
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						func_q  <= func;
						size_q  <= request_size;
						addr_q  <= block_address;
						k_q     <= block_order;
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					node_q <= '0;
					ord_q  <= ORD_W'(LEVELS);
					unit_q <= '0;
					res_q  <= '{ST_OK, '0, '0};
					if (!func_q) begin
						k_q <= k_d;
						if (too_big) begin
							res_q.status <= ST_NO_SPACE;
							state_q      <= S_DONE;
						end else begin
							state_q <= S_A_CHK;
						end
					end else if (k_q > ORD_W'(LEVELS) || misaligned) begin
						res_q.status <= ST_NO_BLOCK;
						state_q      <= S_DONE;
					end else begin
						state_q <= S_F_DESC;
					end
				end
				S_A_CHK: begin
					if (root_short) begin
						res_q.status <= ST_NO_SPACE;
						state_q      <= S_DONE;
					end else if (!rd_data.split) begin
						if (ord_q == k_q) begin
							res_q <= '{ST_OK, {unit_q, {MIN_LOG2{1'b0}}}, k_q};
							cur_q <= '0;
							state_q <= (node_q == '0) ? S_DONE : S_UP;
						end else begin
							state_q <= S_A_SPL;
						end
					end else begin
						state_q <= S_A_LEFT;
					end
				end
				S_A_LEFT: begin
					node_q <= a_next;
					if (!go_left) unit_q[UIDX_W'(ord_q - ORD_W'(1))] <= 1'b1;
					ord_q   <= ord_q - ORD_W'(1);
					state_q <= S_A_CHK;
				end
				S_A_SPL: begin
					state_q <= S_A_SPR;
				end
				S_A_SPR: begin
					node_q  <= left_n;
					ord_q   <= ord_q - ORD_W'(1);
					state_q <= S_A_CHK;
				end
				S_F_DESC: begin
					if (ord_q == k_q) begin
						if (rd_data.split) begin
							res_q.status <= ST_INTERNAL;
							state_q      <= S_DONE;
						end else if (rd_data.free != '0) begin
							res_q.status <= ST_NO_BLOCK;
							state_q      <= S_DONE;
						end else begin
							state_q <= (node_q == '0) ? S_DONE : S_F_MRG;
						end
					end else if (!rd_data.split) begin
						res_q.status <= ST_NO_BLOCK;
						state_q      <= S_DONE;
					end else begin
						node_q  <= f_next;
						ord_q   <= ord_q - ORD_W'(1);
						state_q <= S_F_DESC;
					end
				end
				S_F_MRG: begin
					if (mrg_ok) begin
						state_q <= S_F_MW1;
					end else begin
						cur_q   <= ord_q + ORD_W'(1);
						state_q <= S_UP;
					end
				end
				S_F_MW1: begin
					state_q <= S_F_MW2;
				end
				S_F_MW2: begin
					node_q  <= par_n;
					ord_q   <= ord_q + ORD_W'(1);
					state_q <= (par_n == '0) ? S_DONE : S_F_MRG;
				end
				S_UP: begin
					cur_q   <= up_max;
					node_q  <= par_n;
					state_q <= (par_n == '0) ? S_DONE : S_UP;
				end
				S_DONE: begin
					if (res_take) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy      = state_q != S_IDLE;
	assign res_valid = state_q == S_DONE;
	assign res       = res_q;

	// The store returns old data on a same-address read and write, so the
	// sequence must never need that.
	assert property (@(posedge clk) disable iff (!arst_n)
		(ram_req.rd_en && ram_req.wr_en) |-> (ram_req.rd_addr != ram_req.wr_addr))
		else $error("node store read and write collide");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE && state_q != S_DEC) |-> (ord_q <= ORD_W'(LEVELS)))
		else $error("tree order out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_q.status != ST_OK) |-> (res_q.addr == '0 && res_q.order == '0))
		else $error("error result carries a grant");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && in_valid) |=> (state_q == S_DEC))
		else $error("accepted word not decoded");

endmodule
